// ----- hw/rtl/averaged_ref_software_pwm_drive_core_assert.svh -----
// assertion macros shared by the drive core
`ifndef AVERAGED_REF_SOFTWARE_PWM_DRIVE_CORE_ASSERT_SVH
`define AVERAGED_REF_SOFTWARE_PWM_DRIVE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ARPWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpwm assertion failed");

// next-cycle implication, checked outside reset
`define ARPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpwm assertion failed");

`endif

// ----- hw/rtl/arpwm_pkg.sv -----
package arpwm_pkg;

   localparam int SAMPLE_W = 10;
   localparam int LEVEL_W  = 8;
   localparam int SCALE_W  = 16;
   localparam int SUM_W    = 15;
   localparam int COUNT_W  = 7;
   localparam int PHASE_W  = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET = 8'd0;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 8'd254;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd22677;

   // bridge codes: bit0 a_in1, bit1 a_in2, bit2 b_in1, bit3 b_in2
   localparam logic [3:0] BRIDGE_STOP    = 4'b0000;
   localparam logic [3:0] BRIDGE_FORWARD = 4'b0101;
   localparam logic [3:0] BRIDGE_REVERSE = 4'b1010;

   typedef enum logic [1:0] {
      REG_MIN_LEVEL = 2'd0,
      REG_MAX_LEVEL = 2'd1,
      REG_SCALE_Q16 = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] speed_sample;
      logic                dir_left;
      logic                dir_right;
   } req_type;

   typedef struct packed {
      logic pwm_pin;
      logic a_in1;
      logic a_in2;
      logic b_in1;
      logic b_in2;
   } rsp_type;

   // one tick after scaling and clamping
   typedef struct packed {
      logic [LEVEL_W-1:0] ref_level;
      logic               dir_left;
      logic               dir_right;
   } meas_type;

endpackage

// ----- hw/rtl/averaged_ref_software_pwm_drive_core.sv -----
// Software PWM drive with block-averaged speed reference. Every accepted tick gives one
// result; the block takes one tick per clock cycle sustained while rsp_ready stays high, and a
// result passes through the input register (loaded at the accepting edge), then the
// scale and clamp register, then the result register. The rate is set by the tick
// state update, which holds the phase counters, the running average, the duty level and the
// bridge setting and finishes one tick per cycle, with the divide by the window length done
// as a multiply by a constant reciprocal.
// Registers: min_level at 0x0, max_level at 0x4, scale_q16 at 0x8; write them only while
// no tick is in flight.
`include "averaged_ref_software_pwm_drive_core_assert.svh"

module averaged_ref_software_pwm_drive_core #(
   parameter int PWM_DIV  = 8,
   parameter int MEAS_DIV = 32,
   parameter int AVG_LEN  = 100
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  arpwm_pkg::req_type                    req_data,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output arpwm_pkg::rsp_type                    rsp_data,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [arpwm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [arpwm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [arpwm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   localparam int PROD_W = arpwm_pkg::SAMPLE_W + arpwm_pkg::SCALE_W;

   logic [arpwm_pkg::LEVEL_W-1:0] min_level_ff, max_level_ff;
   logic [arpwm_pkg::SCALE_W-1:0] scale_ff;

   logic                       in_valid_ff;
   arpwm_pkg::req_type         in_data_ff;
   logic                       ref_valid_ff;
   arpwm_pkg::meas_type        ref_data_ff, ref_data_in;
   logic                       rsp_valid_ff;
   arpwm_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                       out_load, ref_load, in_load;
   logic                       csr_write;
   arpwm_pkg::reg_index_type   csr_index;
   logic [PROD_W-1:0]          scale_prod;
   logic [arpwm_pkg::SAMPLE_W-1:0] scaled, lo_clamped, hi_clamped;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = arpwm_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         arpwm_pkg::REG_MIN_LEVEL: csr_prdata = arpwm_pkg::CSR_DATA_W'(min_level_ff);
         arpwm_pkg::REG_MAX_LEVEL: csr_prdata = arpwm_pkg::CSR_DATA_W'(max_level_ff);
         arpwm_pkg::REG_SCALE_Q16: csr_prdata = arpwm_pkg::CSR_DATA_W'(scale_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= arpwm_pkg::MIN_LEVEL_RESET;
         max_level_ff <= arpwm_pkg::MAX_LEVEL_RESET;
         scale_ff     <= arpwm_pkg::SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            arpwm_pkg::REG_MIN_LEVEL: min_level_ff <= csr_pwdata[arpwm_pkg::LEVEL_W-1:0];
            arpwm_pkg::REG_MAX_LEVEL: max_level_ff <= csr_pwdata[arpwm_pkg::LEVEL_W-1:0];
            arpwm_pkg::REG_SCALE_Q16: scale_ff     <= csr_pwdata[arpwm_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow: each stage moves when the one after it has room
   assign out_load  = ref_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign ref_load  = in_valid_ff && (!ref_valid_ff || out_load);
   assign req_ready = !in_valid_ff || ref_load;
   assign in_load   = req_valid && req_ready;

   // scale then clamp, the upper clamp winning when the limits cross
   always_comb begin
      scale_prod = PROD_W'(in_data_ff.speed_sample) * PROD_W'(scale_ff);
      scaled     = scale_prod[PROD_W-1:arpwm_pkg::SCALE_W];
      lo_clamped = (scaled < arpwm_pkg::SAMPLE_W'(min_level_ff)) ?
                   arpwm_pkg::SAMPLE_W'(min_level_ff) : scaled;
      hi_clamped = (lo_clamped > arpwm_pkg::SAMPLE_W'(max_level_ff)) ?
                   arpwm_pkg::SAMPLE_W'(max_level_ff) : lo_clamped;
      ref_data_in.ref_level = hi_clamped[arpwm_pkg::LEVEL_W-1:0];
      ref_data_in.dir_left  = in_data_ff.dir_left;
      ref_data_in.dir_right = in_data_ff.dir_right;
   end

   arpwm_state #(
      .PWM_DIV  (PWM_DIV),
      .MEAS_DIV (MEAS_DIV),
      .AVG_LEN  (AVG_LEN)
   ) u_state (
      .clock (clock),
      .reset (reset),
      .step  (out_load),
      .meas  (ref_data_ff),
      .rsp   (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ref_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (ref_load) begin
            in_valid_ff <= 1'b0;
         end
         if (ref_load) begin
            ref_valid_ff <= 1'b1;
         end else if (out_load) begin
            ref_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (ref_load) begin
         ref_data_ff <= ref_data_in;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a bridge half is never driven both ways
   `ARPWM_ASSERT_NOW(a_bridge_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_data_ff.a_in1 && rsp_data_ff.a_in2) && !(rsp_data_ff.b_in1 && rsp_data_ff.b_in2))
   // a held input tick is never dropped
   `ARPWM_ASSERT_NEXT(a_input_kept, clock, reset, in_valid_ff && !ref_load, in_valid_ff)
   // a scaled tick reaches an empty result register in the next cycle
   `ARPWM_ASSERT_NEXT(a_result_filled, clock, reset, ref_valid_ff && !rsp_valid_ff,
      rsp_valid_ff)

endmodule

// ----- hw/rtl/arpwm_state.sv -----
module arpwm_state #(
   parameter int PWM_DIV  = 8,
   parameter int MEAS_DIV = 32,
   parameter int AVG_LEN  = 100
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  arpwm_pkg::meas_type meas,
   output arpwm_pkg::rsp_type  rsp
);

   // exact reciprocal for a 15 bit dividend and a divisor below 128
   localparam int DIV_SHIFT = arpwm_pkg::SUM_W + arpwm_pkg::COUNT_W;
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam longint DIV_MULT = ((64'd1 << DIV_SHIFT) + AVG_LEN - 1) / AVG_LEN;
   localparam int PROD_W    = arpwm_pkg::SUM_W + MULT_W;

   logic [arpwm_pkg::PHASE_W-1:0] tick_phase_ff, tick_phase_in;
   logic [arpwm_pkg::PHASE_W-1:0] pwm_phase_ff, pwm_phase_in;
   logic [arpwm_pkg::LEVEL_W-1:0] pwm_count_ff, pwm_count_in;
   logic [arpwm_pkg::LEVEL_W-1:0] duty_level_ff, duty_level_in;
   logic [arpwm_pkg::SUM_W-1:0]   avg_sum_ff, avg_sum_in;
   logic [arpwm_pkg::COUNT_W-1:0] avg_count_ff, avg_count_in;
   logic                          pwm_hold_ff, pwm_hold_in;
   logic [3:0]                    bridge_ff, bridge_in;

   logic [arpwm_pkg::PHASE_W:0]   tick_inc, pwm_inc;
   logic                          do_meas, do_pwm;
   logic [arpwm_pkg::SUM_W-1:0]   sum_add;
   logic [arpwm_pkg::COUNT_W-1:0] count_add;
   logic [PROD_W-1:0]             quot_prod;

   always_comb begin
      tick_inc = {1'b0, tick_phase_ff} + 1'b1;
      pwm_inc  = {1'b0, pwm_phase_ff} + 1'b1;
      tick_phase_in = (tick_inc >= (arpwm_pkg::PHASE_W+1)'(MEAS_DIV)) ?
                      '0 : tick_inc[arpwm_pkg::PHASE_W-1:0];
      pwm_phase_in  = (pwm_inc >= (arpwm_pkg::PHASE_W+1)'(PWM_DIV)) ?
                      '0 : pwm_inc[arpwm_pkg::PHASE_W-1:0];
      do_meas = (tick_phase_in == '0);
      do_pwm  = (pwm_phase_in == '0);

      sum_add   = avg_sum_ff + arpwm_pkg::SUM_W'(meas.ref_level);
      count_add = avg_count_ff + 1'b1;
      quot_prod = PROD_W'(sum_add) * PROD_W'(DIV_MULT);

      avg_sum_in    = avg_sum_ff;
      avg_count_in  = avg_count_ff;
      duty_level_in = duty_level_ff;
      bridge_in     = bridge_ff;
      if (do_meas) begin
         if (count_add >= arpwm_pkg::COUNT_W'(AVG_LEN)) begin
            duty_level_in = quot_prod[DIV_SHIFT +: arpwm_pkg::LEVEL_W];
            avg_sum_in    = '0;
            avg_count_in  = '0;
         end else begin
            avg_sum_in   = sum_add;
            avg_count_in = count_add;
         end
         // mixed requests keep the bridge as it is
         if (meas.dir_left && meas.dir_right) begin
            bridge_in = arpwm_pkg::BRIDGE_FORWARD;
         end else if (!meas.dir_left && !meas.dir_right) begin
            bridge_in = arpwm_pkg::BRIDGE_REVERSE;
         end
      end

      pwm_hold_in  = pwm_hold_ff;
      pwm_count_in = pwm_count_ff;
      if (do_pwm) begin
         pwm_hold_in  = (pwm_count_ff <= duty_level_in);
         pwm_count_in = pwm_count_ff + 1'b1;
      end

      rsp.pwm_pin = pwm_hold_in;
      rsp.a_in1   = bridge_in[0];
      rsp.a_in2   = bridge_in[1];
      rsp.b_in1   = bridge_in[2];
      rsp.b_in2   = bridge_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_phase_ff <= '0;
         pwm_phase_ff  <= '0;
         pwm_count_ff  <= '0;
         duty_level_ff <= '0;
         avg_sum_ff    <= '0;
         avg_count_ff  <= '0;
         pwm_hold_ff   <= 1'b0;
         bridge_ff     <= arpwm_pkg::BRIDGE_STOP;
      end else if (step) begin
         tick_phase_ff <= tick_phase_in;
         pwm_phase_ff  <= pwm_phase_in;
         pwm_count_ff  <= pwm_count_in;
         duty_level_ff <= duty_level_in;
         avg_sum_ff    <= avg_sum_in;
         avg_count_ff  <= avg_count_in;
         pwm_hold_ff   <= pwm_hold_in;
         bridge_ff     <= bridge_in;
      end
   end

endmodule
